FILE: hw/rtl/hsfs_pkg.sv
// ----------------------------------------------------------------------------
// hsfs_pkg
// shared types and codes of the scaled forward step
// ----------------------------------------------------------------------------
package hsfs_pkg;

  localparam int MAX_STATES  = 8;
  localparam int MAX_SYMBOLS = 16;

  typedef enum logic [2:0] {
    OP_LOAD_INIT  = 3'd0,
    OP_LOAD_TRANS = 3'd1,
    OP_LOAD_EMIS  = 3'd2,
    OP_LOAD_THR   = 3'd3,
    OP_OBSERVE    = 3'd4
  } op_t;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_OBSERVED = 3'd1;
  localparam logic [2:0] ST_OOR      = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  localparam logic CFG_STATE_COUNT  = 1'b0;
  localparam logic CFG_SYMBOL_COUNT = 1'b1;

  localparam logic [15:0] ONE_Q15 = 16'd32768;

  function automatic logic [15:0] sat_prob(input logic [15:0] v);
    sat_prob = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

FILE: hw/rtl/hmm_scaled_forward_step.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step
// scaled forward recursion of a hidden markov model
// ----------------------------------------------------------------------------
// Usage: in_* carries one transaction per item (loads or observe); out_*
// returns results, one per item for loads and errors, N per successful
// observe (state 0..N-1, out_last on the final one). cfg_* writes
// state_count (index 0) and symbol_count (index 1) while the block is idle.
// Tables and alphas live in synchronous memories, read and
// written back by a sequencer; one item is processed at a time.
// Sequence: a load writes its table and offers a registered result. An
// observe tries the thresholds in turn, then runs a multiply-accumulate
// pass over the states (init times emission for the first item of a
// sequence, else the alpha-weighted transition sum times emission), then
// divides each state's term by the sum in the bit-serial divider.
// Reset clears the state machine, the alpha valid bits (alphas read zero)
// and sets state_count and symbol_count to 2. A stalled receiver holds
// the result register; the block waits with it before the next division.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step
  import hsfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_row_index,
  input  logic [3:0]  in_column_index,
  input  logic [15:0] in_value,
  input  logic        in_first_of_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_symbol,
  output logic [2:0]  out_state_index,
  output logic [15:0] out_alpha_value,
  output logic [31:0] out_normalizer,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int YW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int NW = SW + 1;
  localparam int YCW = YW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_THR_RD, S_THR_CHK, S_MAC_RD, S_MAC_ACC, S_U_DONE,
    S_SUM, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  state_t state_r;

  // memories
  logic [15:0] init_mem  [MAX_STATES];
  logic [15:0] trans_mem [MAX_STATES*MAX_STATES];
  logic [15:0] emis_mem  [MAX_STATES*MAX_SYMBOLS];
  logic [15:0] thr_mem   [MAX_SYMBOLS];
  logic [15:0] alpha_mem [MAX_STATES];
  logic [MAX_STATES-1:0] alpha_vld_r;
  logic [47:0] u_mem [MAX_STATES];

  logic [3:0] n_cfg_r;
  logic [4:0] s_cfg_r;
  logic [NW-1:0] n_use;
  logic [YCW-1:0] s_use;

  always_comb begin
    n_use = (n_cfg_r == 4'd0) ? NW'(1)
          : ({28'd0, n_cfg_r} > MAX_STATES) ? NW'(MAX_STATES) : NW'(n_cfg_r);
    s_use = (s_cfg_r == 5'd0) ? YCW'(1)
          : ({27'd0, s_cfg_r} > MAX_SYMBOLS) ? YCW'(MAX_SYMBOLS) : YCW'(s_cfg_r);
  end

  // latched item
  logic [2:0]  op_r;
  logic [2:0]  row_r;
  logic [3:0]  col_r;
  logic [15:0] val_r;
  logic        first_r;

  // loop state
  logic [YCW-1:0] k_r;
  logic [NW-1:0]  i_r, j_r;
  logic [YW-1:0]  sym_r;
  logic [47:0]    acc_r;
  logic [50:0]    sum_r;
  logic [15:0]    rd_a_r, rd_b_r, rd_e_r, rd_t_r;
  logic [31:0]    prod_r;

  logic [2:0]  o_status_r;
  logic [3:0]  o_symbol_r;
  logic [2:0]  o_idx_r;
  logic [15:0] o_alpha_r;
  logic [31:0] o_norm_r;
  logic        o_last_r, o_valid_r;

  logic        dv_start;
  logic [63:0] dv_num;
  logic [50:0] dv_den;
  logic        dv_done;
  logic [63:0] dv_q;
  logic [47:0] u_rd_r;

  hsfs_div #(.NW(64), .DW(51)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_q)
  );

  assign dv_den = sum_r;
  assign dv_num = {1'b0, u_rd_r, 15'd0} + {14'd0, sum_r[50:1]};

  logic [SW-1:0] i_s, j_s;
  assign i_s = i_r[SW-1:0];
  assign j_s = j_r[SW-1:0];

  logic load_bad;
  always_comb begin
    load_bad = 1'b0;
    if (op_r != OP_LOAD_THR && {1'b0, row_r} >= 4'(n_use)) load_bad = 1'b1;
    if (op_r == OP_LOAD_TRANS && {1'b0, col_r} >= 5'(n_use)) load_bad = 1'b1;
    if ((op_r == OP_LOAD_EMIS || op_r == OP_LOAD_THR) && {1'b0, col_r} >= 5'(s_use))
      load_bad = 1'b1;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !o_valid_r;
  assign out_valid = o_valid_r;
  assign out_status = o_status_r;
  assign out_symbol = o_symbol_r;
  assign out_state_index = o_idx_r;
  assign out_alpha_value = o_alpha_r;
  assign out_normalizer = o_norm_r;
  assign out_last = o_last_r;

  // memory ports: synchronous reads registered
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && !load_bad) begin
      unique case (op_r)
        OP_LOAD_INIT:  init_mem[row_r[SW-1:0]] <= sat_prob(val_r);
        OP_LOAD_TRANS: trans_mem[{row_r[SW-1:0], col_r[SW-1:0]}] <= sat_prob(val_r);
        OP_LOAD_EMIS:  emis_mem[{row_r[SW-1:0], col_r[YW-1:0]}] <= sat_prob(val_r);
        OP_LOAD_THR:   thr_mem[col_r[YW-1:0]] <= val_r;
        default: ;
      endcase
    end
    rd_t_r <= thr_mem[k_r[YW-1:0]];
    rd_a_r <= alpha_vld_r[i_s] ? alpha_mem[i_s] : 16'd0;
    rd_b_r <= first_r ? init_mem[j_s] : trans_mem[{i_s, j_s}];
    rd_e_r <= emis_mem[{j_s, sym_r}];
    u_rd_r <= u_mem[j_s];
    if (state_r == S_U_DONE) u_mem[j_s] <= acc_r;
    if (state_r == S_DIV_WAIT && dv_done) alpha_mem[j_s] <= sat_prob(dv_q[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      o_valid_r   <= 1'b0;
      alpha_vld_r <= '0;
      n_cfg_r     <= 4'd2;
      s_cfg_r     <= 5'd2;
      dv_start    <= 1'b0;
    end else begin
      dv_start <= 1'b0;
      if (o_valid_r && out_ready) o_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STATE_COUNT) n_cfg_r <= cfg_data[3:0];
        else s_cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_operation; row_r <= in_row_index; col_r <= in_column_index;
            val_r <= in_value; first_r <= in_first_of_sequence;
            k_r <= '0; i_r <= '0; j_r <= '0; sym_r <= '0;
            acc_r <= '0; sum_r <= '0;
            state_r <= (in_operation == OP_OBSERVE) ? S_THR_RD : S_LOAD;
          end
        end
        S_LOAD: if (!o_valid_r) begin
          o_status_r <= (op_r > OP_LOAD_THR || load_bad) ? ST_BAD : ST_LOADED;
          o_symbol_r <= '0; o_idx_r <= '0; o_alpha_r <= '0; o_norm_r <= '0;
          o_last_r <= 1'b1; o_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_THR_RD: state_r <= S_THR_CHK;
        S_THR_CHK: begin
          if (val_r <= rd_t_r) begin
            sym_r <= k_r[YW-1:0];
            state_r <= S_MAC_RD;
          end else if (k_r + 1'b1 >= s_use) begin
            if (!o_valid_r) begin
              o_status_r <= ST_OOR; o_symbol_r <= '0; o_idx_r <= '0;
              o_alpha_r <= '0; o_norm_r <= '0; o_last_r <= 1'b1; o_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            k_r <= k_r + 1'b1;
            state_r <= S_THR_RD;
          end
        end
        // read alpha[i], trans[i][j] (or init[j]) and emis[j][sym]
        S_MAC_RD: state_r <= S_MAC_ACC;
        S_MAC_ACC: begin
          if (first_r) begin
            acc_r <= 48'(rd_b_r) * 48'(rd_e_r);
            state_r <= S_U_DONE;
          end else begin
            prod_r <= 32'(rd_a_r) * 32'(rd_b_r);
            if (i_r != '0) acc_r <= acc_r + 48'(prod_r);
            if (i_r + 1'b1 >= n_use && i_r != NW'(MAX_STATES)) begin
              i_r <= NW'(MAX_STATES);   // repeat this state to add the last product
              state_r <= S_MAC_ACC;
            end else if (i_r == NW'(MAX_STATES)) begin
              state_r <= S_SUM;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_MAC_RD;
            end
          end
        end
        S_SUM: begin
          acc_r <= 48'((acc_r * 48'(rd_e_r)) >> 15);
          state_r <= S_U_DONE;
        end
        S_U_DONE: begin
          sum_r <= sum_r + 51'(acc_r);
          acc_r <= '0; i_r <= '0;
          if (j_r + 1'b1 >= n_use) begin
            j_r <= '0;
            state_r <= S_DIV_GO;
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= S_MAC_RD;
          end
        end
        S_DIV_GO: begin
          if (sum_r == '0) begin
            if (!o_valid_r) begin
              o_status_r <= ST_ZERO; o_symbol_r <= 4'(sym_r); o_idx_r <= '0;
              o_alpha_r <= '0; o_norm_r <= '0; o_last_r <= 1'b1; o_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else if (!o_valid_r) begin
            dv_start <= 1'b1;   // u_rd_r for j is read at this edge
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: if (dv_done) begin
          alpha_vld_r[j_s] <= 1'b1;
          o_alpha_r <= sat_prob(dv_q[15:0]);
          o_norm_r <= (sum_r > 51'h4000_0000) ? 32'h8000_0000 : 32'({sum_r, 1'b0});
          o_status_r <= ST_OBSERVED; o_symbol_r <= 4'(sym_r); o_idx_r <= 3'(j_r);
          o_last_r <= (j_r + 1'b1 >= n_use);
          state_r <= S_OUT;
        end
        S_OUT: if (!o_valid_r) begin
          o_valid_r <= 1'b1;
          if (o_last_r) state_r <= S_IDLE;
          else begin
            j_r <= j_r + 1'b1;
            state_r <= S_DIV_GO;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // divider start is registered, so u_rd_r of the new j is in place when it loads
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !out_ready |=> o_valid_r) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !out_ready |=> $stable({o_status_r, o_symbol_r, o_idx_r,
                                         o_alpha_r, o_norm_r, o_last_r}))
    else $error("result changed while waiting");
  a_busy_noin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == S_IDLE) else $error("cfg while busy");

endmodule

FILE: hw/rtl/hsfs_div.sv
// ----------------------------------------------------------------------------
// hsfs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hsfs_div
  import hsfs_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   shl;

  always_comb begin
    shl     = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = shl;
    if (shl >= {1'b0, den_r}) begin
      rem_nxt  = shl - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: tb/hmm_scaled_forward_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_tb
// self-checking bench: table loads and observation sequences are predicted
// by a local forward-step model and checked field by field against the
// result channel, under random idling, back pressure and several settings
// of state_count and symbol_count
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_tb;
  import hsfs_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  row;
    logic [3:0]  col;
    logic [15:0] val;
    logic        first;
  } obs_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  symbol;
    logic [2:0]  state_index;
    logic [15:0] alpha;
    logic [31:0] norm;
    logic        last;
  } alpha_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [2:0] in_row_index = '0;
  logic [3:0] in_column_index = '0;
  logic [15:0] in_value = '0;
  logic in_first_of_sequence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [3:0] out_symbol;
  logic [2:0] out_state_index;
  logic [15:0] out_alpha_value;
  logic [31:0] out_normalizer;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  hmm_scaled_forward_step u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the block's state
  logic [3:0]  m_states;
  logic [4:0]  m_symbols;
  logic [15:0] m_init [8];
  logic [15:0] m_trans [64];
  logic [15:0] m_emis [128];
  logic [15:0] m_thr [16];
  logic [15:0] m_alpha [8];

  obs_item_t  pending_items [$];
  alpha_res_t expected_alphas [$];
  obs_item_t  cur_item;
  int  send_gap = 0, recv_gap = 0;
  logic hold_out = 1'b0, quiet = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;

  function automatic logic [15:0] clamp_q15(logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic alpha_res_t short_res(logic [2:0] st, logic [3:0] sym);
    alpha_res_t r;
    r = '0;
    r.status = st;
    r.symbol = sym;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic forward_step(obs_item_t it);
    int n, s, sym;
    bit found, bad;
    longint unsigned u [8];
    longint unsigned sum, p, nrm, a;
    alpha_res_t r;
    n = (m_states < 1) ? 1 : (m_states > 8) ? 8 : m_states;
    s = (m_symbols < 1) ? 1 : (m_symbols > 16) ? 16 : m_symbols;
    if (it.op <= OP_LOAD_THR) begin
      bad = 0;
      if (it.op != OP_LOAD_THR && it.row >= n) bad = 1;
      if (it.op == OP_LOAD_TRANS && it.col >= n) bad = 1;
      if ((it.op == OP_LOAD_EMIS || it.op == OP_LOAD_THR) && it.col >= s) bad = 1;
      if (!bad) begin
        case (it.op)
          OP_LOAD_INIT:  m_init[it.row] = clamp_q15(it.val);
          OP_LOAD_TRANS: m_trans[it.row * 8 + it.col] = clamp_q15(it.val);
          OP_LOAD_EMIS:  m_emis[it.row * 16 + it.col] = clamp_q15(it.val);
          default:       m_thr[it.col] = it.val;
        endcase
      end
      expected_alphas = {expected_alphas, short_res(bad ? ST_BAD : ST_LOADED, 4'd0)};
      return;
    end
    if (it.op != OP_OBSERVE) begin
      expected_alphas = {expected_alphas, short_res(ST_BAD, 4'd0)};
      return;
    end
    found = 0;
    sym = 0;
    for (int i = 0; i < s; i++) begin
      if (!found && it.val <= m_thr[i]) begin
        sym = i;
        found = 1;
      end
    end
    if (!found) begin
      expected_alphas = {expected_alphas, short_res(ST_OOR, 4'd0)};
      return;
    end
    sum = 0;
    for (int j = 0; j < n; j++) begin
      if (it.first) u[j] = longint'(m_init[j]) * m_emis[j * 16 + sym];
      else begin
        p = 0;
        for (int i = 0; i < n; i++) p += longint'(m_alpha[i]) * m_trans[i * 8 + j];
        u[j] = (p * m_emis[j * 16 + sym]) >> 15;
      end
      sum += u[j];
    end
    if (sum == 0) begin
      expected_alphas = {expected_alphas, short_res(ST_ZERO, sym[3:0])};
      return;
    end
    nrm = sum << 1;
    if (nrm > 64'h8000_0000) nrm = 64'h8000_0000;
    for (int j = 0; j < n; j++) begin
      a = ((u[j] << 15) + (sum >> 1)) / sum;
      m_alpha[j] = (a > ONE_Q15) ? ONE_Q15 : a[15:0];
      r.status = ST_OBSERVED;
      r.symbol = sym[3:0];
      r.state_index = j[2:0];
      r.alpha = m_alpha[j];
      r.norm = nrm[31:0];
      r.last = (j == n - 1);
      expected_alphas = {expected_alphas, r};
    end
  endtask

  // driver
  always @(posedge clk) begin
    obs_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) forward_step(cur_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          cur_item <= it;
          in_operation <= it.op;
          in_row_index <= it.row;
          in_column_index <= it.col;
          in_value <= it.val;
          in_first_of_sequence <= it.first;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 6) == 0) send_gap <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alpha_res_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_status, out_symbol, out_state_index, out_alpha_value,
               out_normalizer, out_last};
        if (expected_alphas.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_alphas.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch exp st=%0d sym=%0d idx=%0d a=%0d n=%0d l=%0d",
                     want.status, want.symbol, want.state_index, want.alpha,
                     want.norm, want.last);
              $display(" got st=%0d sym=%0d idx=%0d a=%0d n=%0d l=%0d",
                       got.status, got.symbol, got.state_index, got.alpha,
                       got.norm, got.last);
            end
          end
        end
      end
      if (hold_out) begin
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (quiet) out_ready <= 1'b1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 6) == 0) recv_gap <= $urandom_range(1, 5);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_item(logic [2:0] op, logic [2:0] row, logic [3:0] col,
                          logic [15:0] val, logic first);
    obs_item_t it;
    it.op = op;
    it.row = row;
    it.col = col;
    it.val = val;
    it.first = first;
    pending_items = {pending_items, it};
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_alphas.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STATE_COUNT) m_states = data[3:0];
    else m_symbols = data;
    @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [2:0] op;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        add_item(OP_OBSERVE, 3'($urandom), 4'($urandom),
                 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40000)),
                 $urandom_range(0, 5) == 0);
      end else begin
        op = 3'($urandom_range(0, 7));
        add_item(op, 3'($urandom), 4'($urandom),
                 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32768)),
                 1'($urandom));
      end
    end
  endtask

  initial begin
    m_states = 2;
    m_symbols = 2;
    foreach (m_alpha[i]) m_alpha[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full tables first so no observation reads an unwritten entry
    write_reg(CFG_STATE_COUNT, 5'd8);
    write_reg(CFG_SYMBOL_COUNT, 5'd16);
    for (int i = 0; i < 8; i++)
      add_item(OP_LOAD_INIT, 3'(i), 4'd0, 16'($urandom_range(0, 32768)), 1'b0);
    for (int i = 0; i < 64; i++)
      add_item(OP_LOAD_TRANS, 3'(i / 8), 4'(i % 8), 16'($urandom_range(0, 32768)), 1'b0);
    for (int i = 0; i < 128; i++)
      add_item(OP_LOAD_EMIS, 3'(i / 16), 4'(i % 16), 16'($urandom_range(1, 32768)), 1'b0);
    for (int i = 0; i < 16; i++)
      add_item(OP_LOAD_THR, 3'd0, 4'(i), 16'(i * 4096 + 4095), 1'b0);
    drain();

    // directed: extremes, unknown codes, zero normalizer
    add_item(OP_OBSERVE, 3'd0, 4'd0, 16'd0, 1'b1);
    add_item(OP_OBSERVE, 3'd7, 4'd15, 16'hFFFF, 1'b0);
    add_item(OP_LOAD_INIT, 3'd7, 4'd15, 16'hFFFF, 1'b1);
    add_item(OP_LOAD_TRANS, 3'd7, 4'd7, 16'd0, 1'b0);
    add_item(OP_OBSERVE, 3'd0, 4'd0, 16'd5000, 1'b0);
    add_item(3'd5, 3'd7, 4'd15, 16'hFFFF, 1'b1);
    add_item(3'd6, 3'd0, 4'd0, 16'd0, 1'b0);
    add_item(3'd7, 3'd3, 4'd9, 16'h5555, 1'b1);
    for (int j = 0; j < 8; j++) add_item(OP_LOAD_EMIS, 3'(j), 4'd0, 16'd0, 1'b0);
    add_item(OP_OBSERVE, 3'd0, 4'd0, 16'd10, 1'b1);
    for (int j = 0; j < 8; j++) add_item(OP_LOAD_EMIS, 3'(j), 4'd0, 16'd20000, 1'b0);
    add_item(OP_OBSERVE, 3'd0, 4'd0, 16'd10, 1'b1);
    drain();

    write_reg(CFG_STATE_COUNT, 5'd3);
    write_reg(CFG_SYMBOL_COUNT, 5'd5);
    add_item(OP_LOAD_INIT, 3'd3, 4'd0, 16'd100, 1'b0);
    add_item(OP_LOAD_TRANS, 3'd0, 4'd3, 16'd100, 1'b0);
    add_item(OP_LOAD_EMIS, 3'd0, 4'd5, 16'd100, 1'b0);
    add_item(OP_LOAD_THR, 3'd7, 4'd5, 16'd100, 1'b0);
    add_item(OP_OBSERVE, 3'd0, 4'd0, 16'd30000, 1'b0);
    random_items(20);
    drain();

    // long receiver hold while the sender keeps offering
    write_reg(CFG_STATE_COUNT, 5'd8);
    write_reg(CFG_SYMBOL_COUNT, 5'd16);
    random_items(20);
    hold_out <= 1'b1;
    @(posedge clk);
    hold_out <= 1'b0;
    drain();

    write_reg(CFG_STATE_COUNT, 5'd0);
    write_reg(CFG_SYMBOL_COUNT, 5'd0);
    random_items(10);
    drain();

    write_reg(CFG_STATE_COUNT, 5'd31);
    write_reg(CFG_SYMBOL_COUNT, 5'd31);
    random_items(15);
    drain();

    write_reg(CFG_STATE_COUNT, 5'd5);
    write_reg(CFG_SYMBOL_COUNT, 5'd11);
    quiet <= 1'b1;
    random_items(20);
    drain();

    if (mismatches == 0 && expected_alphas.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
